// ----- hw/rtl/drc_pkg.sv -----
// ----------------------------------------------------------------------------
// drc_pkg: shared types and constants for the de Rham curve point core
// Field widths, register map, coefficient bundle and fixed-point constants.
// ----------------------------------------------------------------------------
package drc_pkg;

   localparam int unsigned POS_W     = 30;   // position fraction width
   localparam int unsigned COORD_W   = 32;   // signed Q1.30 coordinate
   localparam int unsigned COEF_W    = 31;   // unsigned Q1.30 coefficient
   localparam int unsigned FRAC_BITS = 30;
   localparam int unsigned PROD_W    = 2 * COORD_W;
   localparam int unsigned SUM_W     = PROD_W + 2;
   localparam int unsigned RND_W     = SUM_W - FRAC_BITS;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [COEF_W-1:0]  COEF_RE_RST = COEF_W'(536870912);
   localparam logic [COEF_W-1:0]  COEF_IM_RST = COEF_W'(309962566);
   localparam logic [COORD_W-1:0] START_X_RST = COORD_W'(536870912);
   localparam logic [COORD_W-1:0] START_Y_RST = '0;

   localparam logic signed [COORD_W-1:0] ONE_Q30  = COORD_W'(64'd1 << FRAC_BITS);
   localparam logic signed [SUM_W-1:0]   HALF_Q30 = SUM_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [RND_W-1:0]   SAT_MAX  = RND_W'(64'h7FFF_FFFF);
   localparam logic signed [RND_W-1:0]   SAT_MIN  = -RND_W'(64'h8000_0000);

   typedef enum logic [2:0] {
      REG_COEF_RE    = 3'd0,
      REG_COEF_IM    = 3'd1,
      REG_START_X    = 3'd2,
      REG_START_Y    = 3'd3,
      REG_CURVE_MODE = 3'd4
   } reg_index_type;

   // Map coefficients: user must keep fixed while pipeline is running, unenforced
   typedef struct packed {
      logic signed [COORD_W-1:0] m0;     // a
      logic signed [COORD_W-1:0] m1;     // 1 - a
      logic signed [COORD_W-1:0] b;      // imaginary part
      logic [COEF_W-1:0]         ox;     // offset for a one bit
      logic [COEF_W-1:0]         oy;
      logic                      koch;   // reflection form
   } coef_type;

endpackage

// ----- hw/rtl/drc_stage.sv -----
// ----------------------------------------------------------------------------
// drc_stage: one fraction digit of the curve map
// Products registered first, then sum, round, offset and saturate.
// ----------------------------------------------------------------------------
module drc_stage #(
   parameter int unsigned DIGIT = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  drc_pkg::coef_type                     coef,
   input  logic                                  in_valid,
   input  logic [drc_pkg::POS_W-1:0]             in_pos,
   input  logic signed [drc_pkg::COORD_W-1:0]    in_x,
   input  logic signed [drc_pkg::COORD_W-1:0]    in_y,
   output logic                                  out_valid,
   output logic [drc_pkg::POS_W-1:0]             out_pos,
   output logic signed [drc_pkg::COORD_W-1:0]    out_x,
   output logic signed [drc_pkg::COORD_W-1:0]    out_y
);

   localparam bit          HAS_BIT = DIGIT < drc_pkg::POS_W;
   localparam int unsigned BIT_IDX = HAS_BIT ? DIGIT : 0;

   logic                                  digit_bit;
   logic signed [drc_pkg::COORD_W-1:0]    m;

   logic                                  valid_a_ff;
   logic                                  bit_a_ff;
   logic [drc_pkg::POS_W-1:0]             pos_a_ff;
   logic signed [drc_pkg::PROD_W-1:0]     p_mx_ff, p_by_ff, p_bx_ff, p_my_ff;
   logic signed [drc_pkg::PROD_W-1:0]     p_mx_in, p_by_in, p_bx_in, p_my_in;

   logic signed [drc_pkg::SUM_W-1:0]      sum_x, sum_y, rnd_x, rnd_y;
   logic signed [drc_pkg::RND_W-1:0]      fl_x, fl_y, v_x, v_y;
   logic [drc_pkg::COEF_W-1:0]            off_x, off_y;

   logic                                  valid_b_ff;
   logic [drc_pkg::POS_W-1:0]             pos_b_ff;
   logic signed [drc_pkg::COORD_W-1:0]    x_ff, y_ff, x_in, y_in;

   // digits beyond the position width count as zero
   assign digit_bit = HAS_BIT ? in_pos[BIT_IDX] : 1'b0;
   assign m         = digit_bit ? coef.m1 : coef.m0;

   always_comb begin
      p_mx_in = drc_pkg::PROD_W'(m) * drc_pkg::PROD_W'(in_x);
      p_my_in = drc_pkg::PROD_W'(m) * drc_pkg::PROD_W'(in_y);
      p_bx_in = drc_pkg::PROD_W'(coef.b) * drc_pkg::PROD_W'(in_x);
      p_by_in = drc_pkg::PROD_W'(coef.b) * drc_pkg::PROD_W'(in_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      bit_a_ff <= digit_bit;
      pos_a_ff <= in_pos;
      p_mx_ff  <= p_mx_in;
      p_my_ff  <= p_my_in;
      p_bx_ff  <= p_bx_in;
      p_by_ff  <= p_by_in;
   end

   always_comb begin
      if (coef.koch) begin
         sum_x = drc_pkg::SUM_W'(p_mx_ff) + drc_pkg::SUM_W'(p_by_ff);
         sum_y = drc_pkg::SUM_W'(p_bx_ff) - drc_pkg::SUM_W'(p_my_ff);
      end else begin
         sum_x = drc_pkg::SUM_W'(p_mx_ff) - drc_pkg::SUM_W'(p_by_ff);
         sum_y = drc_pkg::SUM_W'(p_bx_ff) + drc_pkg::SUM_W'(p_my_ff);
      end
      // round half up, then floor by dropping the fraction bits
      rnd_x = sum_x + drc_pkg::HALF_Q30;
      rnd_y = sum_y + drc_pkg::HALF_Q30;
      fl_x  = rnd_x[drc_pkg::SUM_W-1:drc_pkg::FRAC_BITS];
      fl_y  = rnd_y[drc_pkg::SUM_W-1:drc_pkg::FRAC_BITS];
      off_x = bit_a_ff ? coef.ox : '0;
      off_y = bit_a_ff ? coef.oy : '0;
      v_x   = fl_x + drc_pkg::RND_W'(off_x);
      v_y   = fl_y + drc_pkg::RND_W'(off_y);

      if (v_x > drc_pkg::SAT_MAX) begin
         x_in = drc_pkg::SAT_MAX[drc_pkg::COORD_W-1:0];
      end else if (v_x < drc_pkg::SAT_MIN) begin
         x_in = drc_pkg::SAT_MIN[drc_pkg::COORD_W-1:0];
      end else begin
         x_in = v_x[drc_pkg::COORD_W-1:0];
      end
      if (v_y > drc_pkg::SAT_MAX) begin
         y_in = drc_pkg::SAT_MAX[drc_pkg::COORD_W-1:0];
      end else if (v_y < drc_pkg::SAT_MIN) begin
         y_in = drc_pkg::SAT_MIN[drc_pkg::COORD_W-1:0];
      end else begin
         y_in = v_y[drc_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      pos_b_ff <= pos_a_ff;
      x_ff     <= x_in;
      y_ff     <= y_in;
   end

   assign out_valid = valid_b_ff;
   assign out_pos   = pos_b_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

endmodule

// ----- hw/rtl/de_rham_curve_point_core.sv -----
// ----------------------------------------------------------------------------
// de_rham_curve_point_core: de Rham curve point evaluator
// Cesaro or Koch map family applied once per position bit, LSB first.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  request   start, busy, req_position               in (busy tied low)
//  result    rsp_valid, rsp_x_out, rsp_y_out         out, one-cycle strobe
//  config    psel, penable, pwrite, paddr, pwdata,   APB-style, pready high
//            prdata, pready
//
// One transaction is taken every cycle; each result passes through two register
// stages per digit (multiply, then round and saturate). Throughput is set by
// the fully unrolled digit chain: one point per cycle. Reset clears the valid
// chain and restores register defaults. The receiver cannot stall, so busy
// stays low.
// ----------------------------------------------------------------------------
module de_rham_curve_point_core #(
   parameter int unsigned DIGITS = 30
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [drc_pkg::POS_W-1:0]                 req_position,
   output logic                                      rsp_valid,
   output logic signed [drc_pkg::COORD_W-1:0]        rsp_x_out,
   output logic signed [drc_pkg::COORD_W-1:0]        rsp_y_out,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [drc_pkg::CSR_ADDR_W-1:0]            paddr,
   input  logic [drc_pkg::CSR_DATA_W-1:0]            pwdata,
   output logic [drc_pkg::CSR_DATA_W-1:0]            prdata,
   output logic                                      pready
);

   logic [drc_pkg::COEF_W-1:0]   coef_re_ff, coef_im_ff;
   logic [drc_pkg::COORD_W-1:0]  start_x_ff, start_y_ff;
   logic                         mode_ff;
   logic                         csr_write;
   drc_pkg::reg_index_type       csr_index;
   drc_pkg::coef_type            coef;

   logic [DIGITS:0]                        valid_s;
   logic [drc_pkg::POS_W-1:0]              pos_s [DIGITS+1];
   logic signed [drc_pkg::COORD_W-1:0]     x_s   [DIGITS+1];
   logic signed [drc_pkg::COORD_W-1:0]     y_s   [DIGITS+1];

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = drc_pkg::reg_index_type'(paddr[drc_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_re_ff <= drc_pkg::COEF_RE_RST;
         coef_im_ff <= drc_pkg::COEF_IM_RST;
         start_x_ff <= drc_pkg::START_X_RST;
         start_y_ff <= drc_pkg::START_Y_RST;
         mode_ff    <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            drc_pkg::REG_COEF_RE:    coef_re_ff <= pwdata[drc_pkg::COEF_W-1:0];
            drc_pkg::REG_COEF_IM:    coef_im_ff <= pwdata[drc_pkg::COEF_W-1:0];
            drc_pkg::REG_START_X:    start_x_ff <= pwdata;
            drc_pkg::REG_START_Y:    start_y_ff <= pwdata;
            drc_pkg::REG_CURVE_MODE: mode_ff    <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         drc_pkg::REG_COEF_RE:    prdata = drc_pkg::CSR_DATA_W'(coef_re_ff);
         drc_pkg::REG_COEF_IM:    prdata = drc_pkg::CSR_DATA_W'(coef_im_ff);
         drc_pkg::REG_START_X:    prdata = start_x_ff;
         drc_pkg::REG_START_Y:    prdata = start_y_ff;
         drc_pkg::REG_CURVE_MODE: prdata = drc_pkg::CSR_DATA_W'(mode_ff);
         default:                 prdata = '0;
      endcase
   end

   // coefs from registers; user keeps stable while items in flight; unenforced
   always_comb begin
      coef.m0   = drc_pkg::COORD_W'(coef_re_ff);
      coef.m1   = drc_pkg::ONE_Q30 - drc_pkg::COORD_W'(coef_re_ff);
      coef.b    = drc_pkg::COORD_W'(coef_im_ff);
      coef.ox   = coef_re_ff;
      coef.oy   = coef_im_ff;
      coef.koch = mode_ff;
   end

   assign valid_s[0] = start & ~busy;
   assign pos_s[0]   = req_position;
   assign x_s[0]     = start_x_ff;
   assign y_s[0]     = start_y_ff;

   for (genvar g = 0; g < DIGITS; g++) begin : g_digit
      drc_stage #(
         .DIGIT(g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .coef      (coef),
         .in_valid  (valid_s[g]),
         .in_pos    (pos_s[g]),
         .in_x      (x_s[g]),
         .in_y      (y_s[g]),
         .out_valid (valid_s[g+1]),
         .out_pos   (pos_s[g+1]),
         .out_x     (x_s[g+1]),
         .out_y     (y_s[g+1])
      );
   end

   assign rsp_valid = valid_s[DIGITS];
   assign rsp_x_out = x_s[DIGITS];
   assign rsp_y_out = y_s[DIGITS];

endmodule
